FILE: design/monf_pkg.sv
// Shared types and codes for the normal-form word multiplier.
// Used by monf_step and by the top level monoid_normal_form_left_multiplier.
package monf_pkg;

    localparam int LETTER_W = 8;
    localparam int RUN_W    = LETTER_W + 1;
    localparam int STATUS_W = 3;
    localparam int ACTION_W = 2;
    localparam int WLEN_W   = 6;

    localparam logic [RUN_W-1:0] LETTER_MAX = RUN_W'(255);

    // item actions
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LMUL   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_NORMAL = 3'd3;
    localparam logic [STATUS_W-1:0] STS_EMPTY      = 3'd4;

    // compare/increment unit result
    typedef struct packed {
        logic             lt;       // stored letter below running letter
        logic             eq;       // stored letter equals running letter
        logic             ovf;      // running letter above the letter range
        logic [RUN_W-1:0] run_inc;  // running letter plus one
    } t_step;

endpackage

FILE: design/monoid_normal_form_left_multiplier.sv
// Top level: normal-form word store with append, left multiply and readout.
// Depends on monf_pkg, monf_ram and monf_step.
//
// Input channel (i_s_*): tuser carries the action (clear, append, left
// multiply, read out), tdata the letter. One item is taken at a time; the
// input is ready only while the sequencer is idle.
// Output channel (o_m_*): one transfer per clear, append or left multiply;
// a readout gives one transfer per stored letter (tlast on the final one),
// or a single transfer with status empty if the word holds no letters.
// Left multiply makes one RAM read and one pass of the compare/increment unit
// per place, with insertion and shift done in the same left-to-right pass;
// readout gives one letter per cycle while the receiver takes them.
// A stalled receiver holds the result register; the sequencer waits until the
// register is free for its result, then returns to idle and may take a new item.
// Synchronous active-low reset empties the word and returns to idle; the
// letter RAM itself is not cleared, only entries below the count are read.
module monoid_normal_form_left_multiplier #(
    parameter int MAX_WORD_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] letter
    input  logic [1:0]  i_s_tuser,   // [1:0] action
    // output channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_letter, [13:8] word_length, [15:14] zero
    output logic        o_m_tlast,   // last
    output logic [2:0]  o_m_tuser    // [2:0] status
);

    localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int CW = $clog2(MAX_WORD_LEN + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_APP  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WORD_LEN);

    // sequencer state
    logic [2:0]                       r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic [CW-1:0]                    r_pos, n_pos;
    logic [monf_pkg::RUN_W-1:0]       r_run, n_run;
    logic                             r_ins, n_ins;
    logic [monf_pkg::LETTER_W-1:0]    r_carry, n_carry;
    logic [monf_pkg::STATUS_W-1:0]    r_status, n_status;

    // result register
    logic                             r_out_valid, n_out_valid;
    logic [monf_pkg::LETTER_W-1:0]    r_out_letter, n_out_letter;
    logic                             r_out_last, n_out_last;
    logic [monf_pkg::STATUS_W-1:0]    r_out_status, n_out_status;
    logic [monf_pkg::WLEN_W-1:0]      r_out_len, n_out_len;

    // RAM and unit signals
    logic                             ram_we, ram_re;
    logic [AW-1:0]                    ram_waddr, ram_raddr;
    logic [monf_pkg::LETTER_W-1:0]    ram_wdata, ram_rdata;
    monf_pkg::t_step                  step;

    logic                             in_xfer;
    logic                             out_free;
    logic [monf_pkg::ACTION_W-1:0]    in_action;
    logic [monf_pkg::LETTER_W-1:0]    in_letter;
    logic [CW-1:0]                    pos_inc;
    logic [CW-1:0]                    count_inc;

    assign in_action = i_s_tuser;
    assign in_letter = i_s_tdata;
    assign in_xfer   = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_valid || i_m_tready;
    assign pos_inc   = r_pos + CW'(1);
    assign count_inc = r_count + CW'(1);

    monf_ram #(
        .WIDTH (monf_pkg::LETTER_W),
        .DEPTH (MAX_WORD_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    monf_step u_step (
        .i_run    (r_run),
        .i_stored (ram_rdata),
        .o_res    (step)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_run        = r_run;
        n_ins        = r_ins;
        n_carry      = r_carry;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_letter = r_out_letter;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        ram_we       = 1'b0;
        ram_waddr    = r_pos[AW-1:0];
        ram_wdata    = r_run[monf_pkg::LETTER_W-1:0];
        ram_re       = 1'b0;
        ram_raddr    = pos_inc[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_run = {1'b0, in_letter};
                    n_pos = '0;
                    n_ins = 1'b0;
                    unique case (in_action)
                        monf_pkg::ACT_CLEAR: begin
                            n_count  = '0;
                            n_status = monf_pkg::STS_OK;
                            n_state  = S_RESP;
                        end
                        monf_pkg::ACT_APPEND: begin
                            if (r_count == MAX_CNT) begin
                                n_status = monf_pkg::STS_FULL;
                                n_state  = S_RESP;
                            end else if (r_count == '0) begin
                                // empty word: write the first letter directly
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = in_letter;
                                n_count   = CW'(1);
                                n_status  = monf_pkg::STS_OK;
                                n_state   = S_RESP;
                            end else begin
                                // fetch the last letter for the order check
                                ram_re    = 1'b1;
                                ram_raddr = AW'(r_count - CW'(1));
                                n_state   = S_APP;
                            end
                        end
                        monf_pkg::ACT_LMUL: begin
                            if (r_count == MAX_CNT) begin
                                n_status = monf_pkg::STS_FULL;
                                n_state  = S_RESP;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_state   = S_MUL;
                            end
                        end
                        monf_pkg::ACT_READ: begin
                            if (r_count == '0) begin
                                n_status = monf_pkg::STS_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_APP: begin
                // letter below the current last letter breaks normal form
                if (!step.lt && !step.eq) begin
                    n_status = monf_pkg::STS_NOT_NORMAL;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[AW-1:0];
                    n_count   = count_inc;
                    n_status  = monf_pkg::STS_OK;
                end
                n_state = S_RESP;
            end

            S_MUL: begin
                if (r_pos == r_count) begin
                    // end of word: place the pending letter at the tail
                    if (!r_ins && step.ovf) begin
                        n_status = monf_pkg::STS_OVERFLOW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = r_ins ? r_carry : r_run[monf_pkg::LETTER_W-1:0];
                        n_count   = count_inc;
                        n_status  = monf_pkg::STS_OK;
                    end
                    n_state = S_RESP;
                end else begin
                    // prefetch the next letter every cycle
                    ram_re = 1'b1;
                    n_pos  = pos_inc;
                    if (!r_ins && step.lt) begin
                        n_run = step.run_inc;
                    end else begin
                        // insert, or shift the displaced letter one place right
                        ram_we    = 1'b1;
                        ram_wdata = r_ins ? r_carry : r_run[monf_pkg::LETTER_W-1:0];
                        n_carry   = ram_rdata;
                        n_ins     = 1'b1;
                    end
                end
            end

            S_READ: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_letter = ram_rdata;
                    n_out_last   = (pos_inc == r_count);
                    n_out_status = monf_pkg::STS_OK;
                    n_out_len    = monf_pkg::WLEN_W'(r_count);
                    ram_re       = 1'b1;
                    n_pos        = pos_inc;
                    if (pos_inc == r_count) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_letter = '0;
                    n_out_last   = 1'b1;
                    n_out_status = r_status;
                    n_out_len    = monf_pkg::WLEN_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_run        <= n_run;
        r_ins        <= n_ins;
        r_carry      <= n_carry;
        r_status     <= n_status;
        r_out_letter <= n_out_letter;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_len, r_out_letter};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_status;

endmodule

FILE: design/monf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module monf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/monf_step.sv
// Shared compare/increment unit: compares a stored letter against the running letter.
// Depends on monf_pkg.
module monf_step (
    input  logic [monf_pkg::RUN_W-1:0]    i_run,
    input  logic [monf_pkg::LETTER_W-1:0] i_stored,
    output monf_pkg::t_step               o_res
);

    logic [monf_pkg::RUN_W-1:0] stored_ext;

    assign stored_ext    = {1'b0, i_stored};
    assign o_res.lt      = stored_ext < i_run;
    assign o_res.eq      = stored_ext == i_run;
    assign o_res.ovf     = i_run > monf_pkg::LETTER_MAX;
    assign o_res.run_inc = i_run + monf_pkg::RUN_W'(1);

endmodule

FILE: test/tb_monoid_normal_form_left_multiplier.sv
// Testbench for monoid_normal_form_left_multiplier: sends clear, append,
// left-multiply and readout transfers and checks each result transfer
// against a behavioral copy of the word store. Depends on monf_pkg.
module tb_monoid_normal_form_left_multiplier;

    localparam int WORD_CAP = 32;

    typedef struct packed {
        logic [7:0] letter;
        logic       last;
        logic [2:0] status;
        logic [5:0] count;
    } t_word_result;

    // Tracks the stored word and queues the results each accepted item should cause
    class t_normal_form_tracker;
        logic [7:0]   letters[WORD_CAP];
        int           count;
        t_word_result pending[$];
        int           errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void push_result(logic [7:0] letter, logic last, logic [2:0] status);
            t_word_result r;
            r.letter = letter;
            r.last   = last;
            r.status = status;
            r.count  = 6'(count);
            pending  = {pending, r};
        endfunction

        function void take_item(logic [1:0] action, logic [7:0] letter);
            logic [2:0] sts;
            int         run;
            int         pos;
            int         i;
            sts = monf_pkg::STS_OK;
            case (action)
                monf_pkg::ACT_CLEAR: begin
                    count = 0;
                end
                monf_pkg::ACT_APPEND: begin
                    if (count >= WORD_CAP) begin
                        sts = monf_pkg::STS_FULL;
                    end else if (count > 0 && letter < letters[count-1]) begin
                        sts = monf_pkg::STS_NOT_NORMAL;
                    end else begin
                        letters[count] = letter;
                        count++;
                    end
                end
                monf_pkg::ACT_LMUL: begin
                    if (count >= WORD_CAP) begin
                        sts = monf_pkg::STS_FULL;
                    end else begin
                        // pass smaller letters, bumping the running letter each time
                        run = letter;
                        pos = 0;
                        while (pos < count && int'(letters[pos]) < run) begin
                            run++;
                            pos++;
                        end
                        if (run > int'(monf_pkg::LETTER_MAX)) begin
                            sts = monf_pkg::STS_OVERFLOW;
                        end else begin
                            for (i = count; i > pos; i--) letters[i] = letters[i-1];
                            letters[pos] = 8'(run);
                            count++;
                        end
                    end
                end
                default: begin
                    // readout: one result per letter, or an empty marker
                    if (count == 0) begin
                        sts = monf_pkg::STS_EMPTY;
                    end else begin
                        for (i = 0; i < count; i++)
                            push_result(letters[i], (i == count - 1), monf_pkg::STS_OK);
                        return;
                    end
                end
            endcase
            push_result(8'd0, 1'b1, sts);
        endfunction

        function void report(string field, logic [15:0] expv, logic [15:0] actv);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expv, actv);
            errors++;
        endfunction

        function void check_result(logic [15:0] tdata, logic tlast, logic [2:0] tuser);
            t_word_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b tuser=%h",
                         $time, tdata, tlast, tuser);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (tdata[7:0] !== e.letter)  report("out_letter", 16'(e.letter), 16'(tdata[7:0]));
            if (tdata[13:8] !== e.count)  report("word_length", 16'(e.count), 16'(tdata[13:8]));
            if (tdata[15:14] !== 2'b00)   report("tdata pad", 16'd0, 16'(tdata[15:14]));
            if (tlast !== e.last)         report("last", 16'(e.last), 16'(tlast));
            if (tuser !== e.status)       report("status", 16'(e.status), 16'(tuser));
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic [1:0]  i_s_tuser  = monf_pkg::ACT_CLEAR;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;
    logic [2:0]  o_m_tuser;

    t_normal_form_tracker tracker = new();
    bit calm = 1'b0;        // no idling on either side while set
    int items_sent = 0;

    monoid_normal_form_left_multiplier #(
        .MAX_WORD_LEN(WORD_CAP)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls with about 30 percent probability, never while calm is set
    always @(negedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // transfer monitor: results first, then the newly accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) tracker.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
            if (i_s_tvalid && o_s_tready) tracker.take_item(i_s_tuser, i_s_tdata);
        end
    end

    // one input transfer, with random idle cycles ahead of it; starts and ends at negedge
    task automatic send_item(logic [1:0] action, logic [7:0] letter);
        while (!calm && $urandom_range(0, 99) < 30) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= action;
        i_s_tdata  <= letter;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        int directed_items;
        int cur;
        int kind;
        bit first_seq;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty readout, not-normal append, overflow, letter extremes
        send_item(monf_pkg::ACT_READ, 8'd0);
        send_item(monf_pkg::ACT_APPEND, 8'd0);
        send_item(monf_pkg::ACT_APPEND, 8'd255);
        send_item(monf_pkg::ACT_APPEND, 8'd10);
        send_item(monf_pkg::ACT_LMUL, 8'd0);
        send_item(monf_pkg::ACT_LMUL, 8'd1);
        send_item(monf_pkg::ACT_LMUL, 8'd255);
        send_item(monf_pkg::ACT_LMUL, 8'd252);
        send_item(monf_pkg::ACT_LMUL, 8'd253);
        send_item(monf_pkg::ACT_READ, 8'd0);
        send_item(monf_pkg::ACT_CLEAR, 8'hFF);
        send_item(monf_pkg::ACT_LMUL, 8'd255);
        send_item(monf_pkg::ACT_APPEND, 8'd255);
        send_item(monf_pkg::ACT_APPEND, 8'd254);
        send_item(monf_pkg::ACT_READ, 8'hAA);
        send_item(monf_pkg::ACT_CLEAR, 8'h55);
        send_item(monf_pkg::ACT_READ, 8'hFF);
        // product x1 x3 times x2 x5: load b, then letters of a from last to first
        send_item(monf_pkg::ACT_APPEND, 8'd2);
        send_item(monf_pkg::ACT_APPEND, 8'd5);
        send_item(monf_pkg::ACT_LMUL, 8'd3);
        send_item(monf_pkg::ACT_LMUL, 8'd1);
        send_item(monf_pkg::ACT_READ, 8'd0);
        directed_items = items_sent;

        // random sequences; the first one always fills the word
        first_seq = 1'b1;
        while (items_sent - directed_items < 260) begin
            calm = (items_sent - directed_items >= 100) && (items_sent - directed_items < 160);
            kind = first_seq ? 6 : $urandom_range(0, 9);
            first_seq = 1'b0;
            if (kind <= 5) begin
                // build a word, left-multiply it a few times, read it out
                send_item(monf_pkg::ACT_CLEAR, 8'($urandom));
                cur = ($urandom_range(0, 4) == 0) ? $urandom_range(220, 255) : $urandom_range(0, 30);
                repeat ($urandom_range(0, 10)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(monf_pkg::ACT_APPEND, 8'($urandom_range(0, cur)));
                    end else begin
                        cur = cur + $urandom_range(0, 3);
                        if (cur > 255) cur = 255;
                        send_item(monf_pkg::ACT_APPEND, 8'(cur));
                    end
                end
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 7) == 0)
                        send_item(monf_pkg::ACT_LMUL, 8'($urandom_range(200, 255)));
                    else
                        send_item(monf_pkg::ACT_LMUL, 8'($urandom_range(0, 40)));
                end
                send_item(monf_pkg::ACT_READ, 8'($urandom));
            end else if (kind <= 7) begin
                // fill to capacity, then push past it
                send_item(monf_pkg::ACT_CLEAR, 8'($urandom));
                cur = $urandom_range(0, 20);
                repeat (WORD_CAP) begin
                    cur = cur + $urandom_range(0, 7);
                    if (cur > 255) cur = 255;
                    send_item(monf_pkg::ACT_APPEND, 8'(cur));
                end
                send_item(monf_pkg::ACT_APPEND, 8'(cur));
                send_item(monf_pkg::ACT_LMUL, 8'($urandom));
                send_item(monf_pkg::ACT_READ, 8'($urandom));
            end else begin
                // noise: any action, any letter
                repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
        i_s_tvalid <= 1'b0;
        calm = 1'b0;

        // drain, then allow for a late stray result
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("tb_monoid_normal_form_left_multiplier passed");
        end else begin
            $display("tb_monoid_normal_form_left_multiplier failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_monoid_normal_form_left_multiplier failed");
        $finish;
    end

endmodule
